/* hdl/fbd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package fbd_pkg;

    // Frame geometry: interior plus a one-cell border on every side
    localparam int FRAME_COLS  = 16;
    localparam int FRAME_ROWS  = 16;
    localparam int STORE_COLS  = FRAME_COLS + 2;
    localparam int STORE_ROWS  = FRAME_ROWS + 2;
    localparam int STORE_CELLS = STORE_COLS * STORE_ROWS;

    localparam int AW = $clog2(STORE_CELLS);   // cell address
    localparam int CW = $clog2(STORE_COLS);    // sweep column counter
    localparam int RW = $clog2(STORE_ROWS);    // sweep row counter

    // Word fields
    localparam int REQ_W    = 2;
    localparam int COORD_W  = 5;
    localparam int PIX_W    = 8;
    localparam int CORNER_W = COORD_W + 1;

    localparam int COL_LSB   = 0;
    localparam int ROW_LSB   = COL_LSB + COORD_W;
    localparam int FX_LSB    = ROW_LSB + COORD_W;
    localparam int FY_LSB    = FX_LSB + PIX_W;
    localparam int INT_LSB   = FY_LSB + PIX_W;
    localparam int S_DATA_W  = ((INT_LSB + PIX_W + 7) / 8) * 8;
    localparam int M_DATA_W  = 8;

    // Request kinds
    localparam logic [REQ_W-1:0] REQ_BLUR = 2'd0;
    localparam logic [REQ_W-1:0] REQ_DOT  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ = 2'd2;

    // Blur neighborhood read order; up is read last so the cell written
    // one step earlier is settled in memory by then
    localparam int TAP_W = 3;
    localparam logic [TAP_W-1:0] TAP_SELF  = 3'd0;
    localparam logic [TAP_W-1:0] TAP_RIGHT = 3'd1;
    localparam logic [TAP_W-1:0] TAP_DOWN  = 3'd2;
    localparam logic [TAP_W-1:0] TAP_LEFT  = 3'd3;
    localparam logic [TAP_W-1:0] TAP_UP    = 3'd4;

    localparam logic [1:0] CORNER_LAST = 2'd3;

    // floor(s/5) = (s*3277)>>14 for every s up to 5*255
    localparam int SUM_W      = $clog2(5 * 255 + 1);
    localparam int DIV5_MUL   = 3277;
    localparam int DIV5_MUL_W = 12;
    localparam int DIV5_SHIFT = 14;
    localparam int PROD_W     = SUM_W + DIV5_MUL_W;

    typedef struct packed {
        logic             req_load;
        logic             clr_we;
        logic [AW-1:0]    clr_addr;
        logic             blur_rd;
        logic [TAP_W-1:0] blur_tap;
        logic [CW-1:0]    blur_col;
        logic [RW-1:0]    blur_row;
        logic             dot_wgt;
        logic             dot_mul;
        logic             dot_rd;
        logic             dot_wr;
        logic [1:0]       dot_corner;
        logic             rd_issue;
        logic             out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

/* hdl/frame_blur_and_antialiased_dot.sv */
`timescale 1ns / 1ps
`default_nettype none

// Frame blur and antialiased dot plotter. Holds an 18x18 frame of 8-bit
// intensities (16x16 interior plus a one-cell border) in one on-chip
// memory with one write and one registered read port. Request kinds on
// s_tuser: blur (in-place five-point average of the interior, column by
// column, top to bottom), dot (Wu-weighted 2x2 saturating add; corners off
// the store are dropped) and read (one word back on m_tdata; zero for a
// cell off the store). Only reads produce an output word.
// After reset the block clears the frame, one cell a cycle, with s_tready
// low. A blur makes five neighbor reads per interior cell through the
// single read port, with each write-back overlapped with the next cell's
// first read. A dot steps through weight, scale, read and write for each
// corner. A read result sits in an output register, and a later request
// is taken while it waits.
module frame_blur_and_antialiased_dot (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // [4:0] col, [9:5] row, [17:10] col_frac, [25:18] row_frac,
    // [33:26] intensity, [39:34] zero
    input  wire logic [fbd_pkg::S_DATA_W-1:0]   s_tdata,
    // [1:0] req_type
    input  wire logic [fbd_pkg::REQ_W-1:0]      s_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // [7:0] cell_value
    output logic [fbd_pkg::M_DATA_W-1:0]        m_tdata
);

    fbd_pkg::dp_cmd_t  cmd;
    fbd_pkg::dp_stat_t stat;

    // sequencer: clear sweep, blur sweep, dot corners, read handshake
    fbd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .req_type (s_tuser),
        .stat     (stat),
        .cmd      (cmd)
    );

    // frame memory, blur accumulate/divide, Wu weights, output register
    fbd_dpath u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .s_tdata  (s_tdata),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

/* hdl/fbd_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module fbd_ctrl (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [fbd_pkg::REQ_W-1:0]  req_type,
    input  wire fbd_pkg::dp_stat_t          stat,
    output fbd_pkg::dp_cmd_t                cmd
);

    typedef enum logic [9:0] {
        ST_CLEAR    = 10'b00_0000_0001,
        ST_IDLE     = 10'b00_0000_0010,
        ST_BLUR     = 10'b00_0000_0100,
        ST_BLUR_END = 10'b00_0000_1000,
        ST_DOT_WGT  = 10'b00_0001_0000,
        ST_DOT_MUL  = 10'b00_0010_0000,
        ST_DOT_RD   = 10'b00_0100_0000,
        ST_DOT_WR   = 10'b00_1000_0000,
        ST_RD_ISSUE = 10'b01_0000_0000,
        ST_RD_HOLD  = 10'b10_0000_0000
    } state_t;

    state_t                     state_reg, state_next;
    logic [fbd_pkg::AW-1:0]     clr_cnt_reg, clr_cnt_next;
    logic [fbd_pkg::TAP_W-1:0]  tap_reg, tap_next;
    logic [fbd_pkg::CW-1:0]     col_reg, col_next;
    logic [fbd_pkg::RW-1:0]     row_reg, row_next;
    logic [1:0]                 corner_reg, corner_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        tap_next     = tap_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        corner_next  = corner_reg;
        cmd          = '0;
        cmd.clr_addr   = clr_cnt_reg;
        cmd.blur_tap   = tap_reg;
        cmd.blur_col   = col_reg;
        cmd.blur_row   = row_reg;
        cmd.dot_corner = corner_reg;

        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clr_we = 1'b1;
                if (clr_cnt_reg == fbd_pkg::AW'(fbd_pkg::STORE_CELLS - 1)) begin
                    state_next = ST_IDLE;
                end else begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.req_load = 1'b1;
                    unique case (req_type)
                        fbd_pkg::REQ_BLUR: begin
                            col_next   = fbd_pkg::CW'(1);
                            row_next   = fbd_pkg::RW'(1);
                            tap_next   = fbd_pkg::TAP_SELF;
                            state_next = ST_BLUR;
                        end
                        fbd_pkg::REQ_DOT: begin
                            corner_next = 2'd0;
                            state_next  = ST_DOT_WGT;
                        end
                        fbd_pkg::REQ_READ: state_next = ST_RD_ISSUE;
                        default:           state_next = ST_IDLE;
                    endcase
                end
            end
            ST_BLUR: begin
                cmd.blur_rd = 1'b1;
                if (tap_reg == fbd_pkg::TAP_UP) begin
                    tap_next = fbd_pkg::TAP_SELF;
                    if (row_reg == fbd_pkg::RW'(fbd_pkg::FRAME_ROWS)) begin
                        row_next = fbd_pkg::RW'(1);
                        if (col_reg == fbd_pkg::CW'(fbd_pkg::FRAME_COLS)) begin
                            state_next = ST_BLUR_END;
                        end else begin
                            col_next = col_reg + 1'b1;
                        end
                    end else begin
                        row_next = row_reg + 1'b1;
                    end
                end else begin
                    tap_next = tap_reg + 1'b1;
                end
            end
            // last cell's write-back lands here
            ST_BLUR_END: state_next = ST_IDLE;
            ST_DOT_WGT: begin
                cmd.dot_wgt = 1'b1;
                state_next  = ST_DOT_MUL;
            end
            ST_DOT_MUL: begin
                cmd.dot_mul = 1'b1;
                state_next  = ST_DOT_RD;
            end
            ST_DOT_RD: begin
                cmd.dot_rd = 1'b1;
                state_next = ST_DOT_WR;
            end
            ST_DOT_WR: begin
                cmd.dot_wr = 1'b1;
                if (corner_reg == fbd_pkg::CORNER_LAST) begin
                    state_next = ST_IDLE;
                end else begin
                    corner_next = corner_reg + 1'b1;
                    state_next  = ST_DOT_WGT;
                end
            end
            ST_RD_ISSUE: begin
                cmd.rd_issue = 1'b1;
                state_next   = ST_RD_HOLD;
            end
            ST_RD_HOLD: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            tap_reg     <= fbd_pkg::TAP_SELF;
            col_reg     <= '0;
            row_reg     <= '0;
            corner_reg  <= '0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            tap_reg     <= tap_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            corner_reg  <= corner_next;
        end
    end

endmodule

`default_nettype wire

/* hdl/fbd_dpath.sv */
`timescale 1ns / 1ps
`default_nettype none

module fbd_dpath (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire fbd_pkg::dp_cmd_t               cmd,
    input  wire logic [fbd_pkg::S_DATA_W-1:0]   s_tdata,
    output fbd_pkg::dp_stat_t                   stat,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [fbd_pkg::M_DATA_W-1:0]        m_tdata
);

    localparam int AW = fbd_pkg::AW;

    // frame memory, one write and one registered read per cycle
    logic [fbd_pkg::PIX_W-1:0] mem [fbd_pkg::STORE_CELLS];
    logic                      mem_we, mem_re;
    logic [AW-1:0]             mem_wa, mem_ra;
    logic [fbd_pkg::PIX_W-1:0] mem_wd;
    logic [fbd_pkg::PIX_W-1:0] rd_data_reg;

    // captured request
    logic [fbd_pkg::COORD_W-1:0] col_reg, row_reg;
    logic [fbd_pkg::PIX_W-1:0]   fx_reg, fy_reg, inten_reg;

    // blur pipeline
    logic [AW-1:0]               blur_base, blur_addr;
    logic                        brd_vld_reg, brd_first_reg, brd_last_reg;
    logic [AW-1:0]               bwr_addr_reg;
    logic [fbd_pkg::SUM_W-1:0]   acc_reg, blur_sum;
    logic [fbd_pkg::PROD_W-1:0]  blur_prod;
    logic [fbd_pkg::PIX_W-1:0]   blur_q;

    // dot path
    logic [fbd_pkg::CORNER_W-1:0] cc, rr;
    logic                         corner_in;
    logic [AW-1:0]                corner_addr;
    logic [fbd_pkg::PIX_W-1:0]    wa, wb;
    logic [15:0]                  wsum;
    logic [fbd_pkg::PIX_W-1:0]    wgt_reg;
    logic [15:0]                  contrib_full;
    logic [fbd_pkg::PIX_W-1:0]    contrib_reg;
    logic [fbd_pkg::PIX_W:0]      dot_sum;
    logic [fbd_pkg::PIX_W-1:0]    dot_sat;

    // read path
    logic                         req_in;
    logic [AW-1:0]                req_addr;
    logic                         rd_in_reg;
    logic                         m_tvalid_reg;
    logic [fbd_pkg::M_DATA_W-1:0] m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (cmd.req_load) begin
            col_reg   <= s_tdata[fbd_pkg::COL_LSB +: fbd_pkg::COORD_W];
            row_reg   <= s_tdata[fbd_pkg::ROW_LSB +: fbd_pkg::COORD_W];
            fx_reg    <= s_tdata[fbd_pkg::FX_LSB +: fbd_pkg::PIX_W];
            fy_reg    <= s_tdata[fbd_pkg::FY_LSB +: fbd_pkg::PIX_W];
            inten_reg <= s_tdata[fbd_pkg::INT_LSB +: fbd_pkg::PIX_W];
        end
    end

    // ---- blur addressing: cell = col*STORE_ROWS + row
    always_comb begin
        blur_base = AW'(cmd.blur_col) * AW'(fbd_pkg::STORE_ROWS) + AW'(cmd.blur_row);
        case (cmd.blur_tap)
            fbd_pkg::TAP_RIGHT: blur_addr = blur_base + AW'(fbd_pkg::STORE_ROWS);
            fbd_pkg::TAP_DOWN:  blur_addr = blur_base + AW'(1);
            fbd_pkg::TAP_LEFT:  blur_addr = blur_base - AW'(fbd_pkg::STORE_ROWS);
            fbd_pkg::TAP_UP:    blur_addr = blur_base - AW'(1);
            default:            blur_addr = blur_base;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            brd_vld_reg <= 1'b0;
        end else begin
            brd_vld_reg <= cmd.blur_rd;
        end
    end

    always_ff @(posedge aclk) begin
        brd_first_reg <= (cmd.blur_tap == fbd_pkg::TAP_SELF);
        brd_last_reg  <= (cmd.blur_tap == fbd_pkg::TAP_UP);
        if (cmd.blur_rd && cmd.blur_tap == fbd_pkg::TAP_SELF) begin
            bwr_addr_reg <= blur_base;
        end
        if (brd_vld_reg) begin
            acc_reg <= brd_first_reg ? fbd_pkg::SUM_W'(rd_data_reg) : blur_sum;
        end
    end

    assign blur_sum  = acc_reg + fbd_pkg::SUM_W'(rd_data_reg);
    assign blur_prod = fbd_pkg::PROD_W'(blur_sum)
                     * fbd_pkg::PROD_W'(fbd_pkg::DIV5_MUL);
    assign blur_q    = blur_prod[fbd_pkg::DIV5_SHIFT +: fbd_pkg::PIX_W];

    // ---- dot: Wu weight, scale by intensity, saturating add
    assign cc = fbd_pkg::CORNER_W'(col_reg) + fbd_pkg::CORNER_W'(cmd.dot_corner[0]);
    assign rr = fbd_pkg::CORNER_W'(row_reg) + fbd_pkg::CORNER_W'(cmd.dot_corner[1]);
    assign corner_in = (32'(cc) < fbd_pkg::STORE_COLS) && (32'(rr) < fbd_pkg::STORE_ROWS);
    assign corner_addr = AW'(cc) * AW'(fbd_pkg::STORE_ROWS) + AW'(rr);

    assign wa   = cmd.dot_corner[0] ? fx_reg : ~fx_reg;   // ~f == 255 - f
    assign wb   = cmd.dot_corner[1] ? fy_reg : ~fy_reg;
    assign wsum = 16'(wa) * 16'(wb) + 16'(wa) + 16'(wb); // max 65535, no carry out
    assign contrib_full = 16'(inten_reg) * 16'(wgt_reg);

    always_ff @(posedge aclk) begin
        if (cmd.dot_wgt) begin
            wgt_reg <= wsum[15:8];
        end
        if (cmd.dot_mul) begin
            contrib_reg <= contrib_full[15:8];
        end
    end

    assign dot_sum = {1'b0, rd_data_reg} + {1'b0, contrib_reg};
    assign dot_sat = dot_sum[fbd_pkg::PIX_W] ? '1 : dot_sum[fbd_pkg::PIX_W-1:0];

    // ---- single cell read
    assign req_in   = (32'(col_reg) < fbd_pkg::STORE_COLS)
                   && (32'(row_reg) < fbd_pkg::STORE_ROWS);
    assign req_addr = AW'(col_reg) * AW'(fbd_pkg::STORE_ROWS) + AW'(row_reg);

    // ---- memory port muxing; sources never overlap
    always_comb begin
        mem_we = 1'b0;
        mem_wa = cmd.clr_addr;
        mem_wd = '0;
        if (cmd.clr_we) begin
            mem_we = 1'b1;
        end else if (brd_vld_reg && brd_last_reg) begin
            mem_we = 1'b1;
            mem_wa = bwr_addr_reg;
            mem_wd = blur_q;
        end else if (cmd.dot_wr && corner_in) begin
            mem_we = 1'b1;
            mem_wa = corner_addr;
            mem_wd = dot_sat;
        end

        mem_re = 1'b0;
        mem_ra = blur_addr;
        if (cmd.blur_rd) begin
            mem_re = 1'b1;
        end else if (cmd.dot_rd && corner_in) begin
            mem_re = 1'b1;
            mem_ra = corner_addr;
        end else if (cmd.rd_issue && req_in) begin
            mem_re = 1'b1;
            mem_ra = req_addr;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            rd_data_reg <= mem[mem_ra];
        end
    end

    // ---- output register
    always_ff @(posedge aclk) begin
        if (cmd.rd_issue) begin
            rd_in_reg <= req_in;
        end
        if (cmd.out_load) begin
            m_tdata_reg <= rd_in_reg ? rd_data_reg : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    assign stat.out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid      = m_tvalid_reg;
    assign m_tdata       = m_tdata_reg;

endmodule

`default_nettype wire
